// ===== sv/gsfp_pkg.sv =====
package gsfp_pkg;

  localparam int MAX_FRAME_LEN = 64;
  localparam int MIN_FRAME_LEN = 4;
  localparam int BLEN_W        = $clog2(MAX_FRAME_LEN - 1);

  localparam logic [7:0] HEADER_BYTE   = 8'hAA;
  localparam logic [7:0] CMD_ATTITUDE  = 8'h14;
  localparam logic [7:0] CMD_HEARTBEAT = 8'h15;

  // Attitude frames need this many body bytes; bytes 0..ATT_SPAN-1 carry payload.
  localparam int ATT_MIN_BODY = 43;
  localparam int ATT_SPAN     = 42;
  localparam int MODE_INDEX   = 13;

  localparam int           TALLY_W       = 17;
  localparam int           LIMIT_W       = 16;
  localparam logic [15:0]  LIMIT_RESET   = 16'd5000;
  localparam logic [2:0]   MODE_MAX      = 3'd4;
  localparam logic [2:0]   MODE_FALLBACK = 3'd1;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LEN  = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_ATTITUDE  = 2'd0,
    KIND_HEARTBEAT = 2'd1,
    KIND_RECONNECT = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       frame_kind;
    logic [2:0]  gimbal_mode;
    logic [31:0] pitch_bits;
    logic [31:0] yaw_bits;
    logic [31:0] quat_w_bits;
    logic [31:0] quat_x_bits;
    logic [31:0] quat_y_bits;
    logic [31:0] quat_z_bits;
    logic [31:0] yaw_rate_bits;
    logic [31:0] pitch_rate_bits;
    logic [31:0] projectile_speed_bits;
  } result_t;

endpackage

// ===== sv/gimbal_serial_frame_parser_top.sv =====
// Gimbal serial frame parser.
//
// Input channel (in_valid / in_stall): one received byte per transfer, or a
// line-error event when in_line_error is set. The parser hunts for header
// 0xAA, takes a frame length byte (4..64) and collects the body. Attitude and
// heartbeat frames produce one result; bad frames and line errors raise an
// error tally, and once it passes cfg_wr_data's limit a reconnect request is
// produced and the tally restarts.
//
// Result channel (out_valid / out_stall): a byte's result is registered in the
// output register, or in the skid register while out_stall holds it. One byte is
// taken every cycle while in_stall is low; all decoding for a byte sits between
// the input port and the output register. A skid register behind the output
// register lets one more result land while the receiver stalls; in_stall rises
// only while the skid register is occupied.
//
// Reset (rst_n low at a clock edge): the parser goes back to hunting, the
// tally clears, the limit returns to 5000 and both result registers empty.
module gimbal_serial_frame_parser_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [15:0]               cfg_wr_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                in_rx_byte,
  input  logic                      in_line_error,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                out_frame_kind,
  output logic [2:0]                out_gimbal_mode,
  output logic [31:0]               out_pitch_bits,
  output logic [31:0]               out_yaw_bits,
  output logic [31:0]               out_quat_w_bits,
  output logic [31:0]               out_quat_x_bits,
  output logic [31:0]               out_quat_y_bits,
  output logic [31:0]               out_quat_z_bits,
  output logic [31:0]               out_yaw_rate_bits,
  output logic [31:0]               out_pitch_rate_bits,
  output logic [31:0]               out_projectile_speed_bits
);
  import gsfp_pkg::*;

  localparam int SH_W = ATT_SPAN * 8;

  phase_t               phase_r, phase_nxt;
  logic [TALLY_W-1:0]   tally_r, tally_nxt;
  logic [LIMIT_W-1:0]   limit_r;
  logic [BLEN_W-1:0]    blen_r, blen_nxt;
  logic [BLEN_W-1:0]    idx_r, idx_nxt;
  logic [SH_W-1:0]      sh_r, sh_nxt;
  logic [7:0]           cmd_r, cmd_nxt;

  result_t              out_r, out_nxt;
  logic                 out_valid_r, out_valid_nxt;
  result_t              skid_r, skid_nxt;
  logic                 skid_valid_r, skid_valid_nxt;

  result_t              res;
  logic                 res_v;
  logic                 accept;
  logic                 take;
  logic                 err_hit;
  logic [TALLY_W-1:0]   tally_inc;
  logic                 tally_trip;
  logic [BLEN_W-1:0]    idx_inc;
  logic [7:0]           mode_raw;

  // Stream byte k of the body sits at byte lane ATT_SPAN-1-k once the line is full.
  function automatic logic [31:0] word_at(input logic [SH_W-1:0] s, input int p);
    logic [31:0] w;
    w = '0;
    for (int k = 0; k < 4; k++) begin
      w[k*8 +: 8] = s[(ATT_SPAN - 1 - p - k)*8 +: 8];
    end
    return w;
  endfunction

  assign in_stall = skid_valid_r;
  assign accept   = in_valid & ~skid_valid_r;
  assign take     = out_valid_r & ~out_stall;

  assign tally_inc  = (tally_r == {TALLY_W{1'b1}}) ? tally_r : tally_r + 1'b1;
  assign tally_trip = tally_inc > {{(TALLY_W-LIMIT_W){1'b0}}, limit_r};
  assign idx_inc    = idx_r + 1'b1;
  assign mode_raw   = sh_r[(ATT_SPAN - 1 - MODE_INDEX)*8 +: 8];

  always_comb begin
    phase_nxt = phase_r;
    tally_nxt = tally_r;
    blen_nxt  = blen_r;
    idx_nxt   = idx_r;
    sh_nxt    = sh_r;
    cmd_nxt   = cmd_r;
    res       = '0;
    res_v     = 1'b0;
    err_hit   = 1'b0;

    if (accept) begin
      if (in_line_error) begin
        phase_nxt = PH_HUNT;
        err_hit   = 1'b1;
      end else begin
        unique case (phase_r)
          PH_HUNT: begin
            phase_nxt = (in_rx_byte == HEADER_BYTE) ? PH_LEN : PH_HUNT;
          end
          PH_LEN: begin
            if (in_rx_byte < 8'(MIN_FRAME_LEN) || in_rx_byte > 8'(MAX_FRAME_LEN)) begin
              phase_nxt = PH_HUNT;
              err_hit   = 1'b1;
            end else begin
              blen_nxt  = BLEN_W'(in_rx_byte - 8'd2);
              idx_nxt   = '0;
              phase_nxt = PH_BODY;
            end
          end
          PH_BODY: begin
            if (idx_r == '0) begin
              cmd_nxt = in_rx_byte;
            end
            // Only the first ATT_SPAN body bytes matter; stop shifting after that.
            if (idx_r < BLEN_W'(ATT_SPAN)) begin
              sh_nxt = {sh_r[SH_W-9:0], in_rx_byte};
            end
            idx_nxt = idx_inc;
            if (idx_inc >= blen_r) begin
              phase_nxt = PH_HUNT;
              if (cmd_r == CMD_ATTITUDE && blen_r >= BLEN_W'(ATT_MIN_BODY)) begin
                res.frame_kind            = KIND_ATTITUDE;
                res.gimbal_mode           = (mode_raw <= 8'(MODE_MAX)) ?
                                            mode_raw[2:0] : MODE_FALLBACK;
                res.pitch_bits            = word_at(sh_r, 1);
                res.yaw_bits              = word_at(sh_r, 9);
                res.quat_w_bits           = word_at(sh_r, 14);
                res.quat_x_bits           = word_at(sh_r, 18);
                res.quat_y_bits           = word_at(sh_r, 22);
                res.quat_z_bits           = word_at(sh_r, 26);
                res.yaw_rate_bits         = word_at(sh_r, 30);
                res.pitch_rate_bits       = word_at(sh_r, 34);
                res.projectile_speed_bits = word_at(sh_r, 38);
                res_v                     = 1'b1;
                tally_nxt                 = '0;
              end else if (cmd_r == CMD_HEARTBEAT) begin
                res.frame_kind = KIND_HEARTBEAT;
                res_v          = 1'b1;
                tally_nxt      = '0;
              end else begin
                err_hit = 1'b1;
              end
            end
          end
          default: begin
            phase_nxt = PH_HUNT;
          end
        endcase
      end
    end

    if (err_hit) begin
      if (tally_trip) begin
        res.frame_kind = KIND_RECONNECT;
        res_v          = 1'b1;
        tally_nxt      = '0;
      end else begin
        tally_nxt = tally_inc;
      end
    end
  end

  // Output register plus skid: drain skid first, park a new result when stalled.
  always_comb begin
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;
    skid_nxt       = skid_r;
    skid_valid_nxt = skid_valid_r;
    if (skid_valid_r) begin
      if (take) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end
    end else if (!out_valid_r || take) begin
      out_nxt       = res;
      out_valid_nxt = res_v;
    end else if (res_v) begin
      skid_nxt       = res;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HUNT;
      tally_r      <= '0;
      limit_r      <= LIMIT_RESET;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      tally_r      <= tally_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    blen_r <= blen_nxt;
    idx_r  <= idx_nxt;
    sh_r   <= sh_nxt;
    cmd_r  <= cmd_nxt;
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid                 = out_valid_r;
  assign out_frame_kind            = out_r.frame_kind;
  assign out_gimbal_mode           = out_r.gimbal_mode;
  assign out_pitch_bits            = out_r.pitch_bits;
  assign out_yaw_bits              = out_r.yaw_bits;
  assign out_quat_w_bits           = out_r.quat_w_bits;
  assign out_quat_x_bits           = out_r.quat_x_bits;
  assign out_quat_y_bits           = out_r.quat_y_bits;
  assign out_quat_z_bits           = out_r.quat_z_bits;
  assign out_yaw_rate_bits         = out_r.yaw_rate_bits;
  assign out_pitch_rate_bits       = out_r.pitch_rate_bits;
  assign out_projectile_speed_bits = out_r.projectile_speed_bits;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds a result while output register is empty");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !out_stall) |=> (out_valid_r && !skid_valid_r))
    else $error("skid register did not move into output register");

  a_line_error_hunts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_line_error) |=> (phase_r == PH_HUNT))
    else $error("line error did not return parser to hunting");

  a_reconnect_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.frame_kind == KIND_RECONNECT) |->
      (out_r.gimbal_mode == '0 && out_r.pitch_bits == '0 && out_r.yaw_bits == '0))
    else $error("reconnect request carries nonzero payload");

  a_result_clears_tally: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && res_v) |=> (tally_r == '0))
    else $error("error tally not cleared after a result");

endmodule

// ===== bench/gimbal_serial_frame_parser_top_test.sv =====
module gimbal_serial_frame_parser_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import gsfp_pkg::*;

  localparam int          BODY_DEPTH  = MAX_FRAME_LEN - 2;
  localparam int          CYCLE_LIMIT = 200000;
  localparam logic [16:0] TALLY_TOP   = {TALLY_W{1'b1}};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = '0;
  logic        in_line_error = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_frame_kind;
  logic [2:0]  out_gimbal_mode;
  logic [31:0] out_pitch_bits;
  logic [31:0] out_yaw_bits;
  logic [31:0] out_quat_w_bits;
  logic [31:0] out_quat_x_bits;
  logic [31:0] out_quat_y_bits;
  logic [31:0] out_quat_z_bits;
  logic [31:0] out_yaw_rate_bits;
  logic [31:0] out_pitch_rate_bits;
  logic [31:0] out_projectile_speed_bits;

  gimbal_serial_frame_parser_top i_dut (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .cfg_wr_en                 (cfg_wr_en),
    .cfg_wr_data               (cfg_wr_data),
    .in_valid                  (in_valid),
    .in_stall                  (in_stall),
    .in_rx_byte                (in_rx_byte),
    .in_line_error             (in_line_error),
    .out_valid                 (out_valid),
    .out_stall                 (out_stall),
    .out_frame_kind            (out_frame_kind),
    .out_gimbal_mode           (out_gimbal_mode),
    .out_pitch_bits            (out_pitch_bits),
    .out_yaw_bits              (out_yaw_bits),
    .out_quat_w_bits           (out_quat_w_bits),
    .out_quat_x_bits           (out_quat_x_bits),
    .out_quat_y_bits           (out_quat_y_bits),
    .out_quat_z_bits           (out_quat_z_bits),
    .out_yaw_rate_bits         (out_yaw_rate_bits),
    .out_pitch_rate_bits       (out_pitch_rate_bits),
    .out_projectile_speed_bits (out_projectile_speed_bits)
  );

  always #4 clk = ~clk;

  // Parser mirror
  phase_t      link_phase = PH_HUNT;
  int          frame_body_len = 0;
  int          body_pos = 0;
  logic [7:0]  body_bytes [BODY_DEPTH];
  logic [16:0] err_tally = '0;
  logic [15:0] err_limit = LIMIT_RESET;

  result_t     pending_results [$];
  int          mismatch_count = 0;
  int          bytes_taken = 0;
  int          results_seen = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  logic [7:0]  frame_buf [BODY_DEPTH];

  function automatic logic [31:0] body_word(input int pos);
    return {body_bytes[pos + 3], body_bytes[pos + 2], body_bytes[pos + 1], body_bytes[pos]};
  endfunction

  // Advance the mirror by one transfer; return 1 when it produces a result.
  function automatic bit parse_byte(input logic [7:0] b, input logic err, output result_t res);
    bit         err_hit;
    bit         got;
    logic [7:0] m;
    err_hit = 1'b0;
    got = 1'b0;
    res = '0;
    if (err) begin
      link_phase = PH_HUNT;
      err_hit = 1'b1;
    end else if (link_phase == PH_LEN) begin
      if (b < MIN_FRAME_LEN || b > MAX_FRAME_LEN) begin
        link_phase = PH_HUNT;
        err_hit = 1'b1;
      end else begin
        frame_body_len = int'(b) - 2;
        body_pos = 0;
        link_phase = PH_BODY;
      end
    end else if (link_phase == PH_BODY) begin
      if (body_pos < BODY_DEPTH) body_bytes[body_pos] = b;
      body_pos++;
      if (body_pos >= frame_body_len) begin
        link_phase = PH_HUNT;
        if (body_bytes[0] == CMD_ATTITUDE && frame_body_len >= ATT_MIN_BODY) begin
          m = body_bytes[MODE_INDEX];
          res.frame_kind = KIND_ATTITUDE;
          res.gimbal_mode = (m <= MODE_MAX) ? m[2:0] : MODE_FALLBACK;
          res.pitch_bits = body_word(1);
          res.yaw_bits = body_word(9);
          res.quat_w_bits = body_word(14);
          res.quat_x_bits = body_word(18);
          res.quat_y_bits = body_word(22);
          res.quat_z_bits = body_word(26);
          res.yaw_rate_bits = body_word(30);
          res.pitch_rate_bits = body_word(34);
          res.projectile_speed_bits = body_word(38);
          err_tally = '0;
          got = 1'b1;
        end else if (body_bytes[0] == CMD_HEARTBEAT) begin
          res.frame_kind = KIND_HEARTBEAT;
          err_tally = '0;
          got = 1'b1;
        end else begin
          err_hit = 1'b1;
        end
      end
    end else begin
      link_phase = (b == HEADER_BYTE) ? PH_LEN : PH_HUNT;
    end
    if (err_hit) begin
      if (err_tally < TALLY_TOP) err_tally++;
      if (err_tally > err_limit) begin
        err_tally = '0;
        res.frame_kind = KIND_RECONNECT;
        got = 1'b1;
      end
    end
    return got;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  always @(posedge clk) begin
    result_t want;
    result_t pred;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $display("%0t: result transfer with nothing pending, kind %0d", $time, out_frame_kind);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("frame_kind", 32'(want.frame_kind), 32'(out_frame_kind));
          check_field("gimbal_mode", 32'(want.gimbal_mode), 32'(out_gimbal_mode));
          check_field("pitch_bits", want.pitch_bits, out_pitch_bits);
          check_field("yaw_bits", want.yaw_bits, out_yaw_bits);
          check_field("quat_w_bits", want.quat_w_bits, out_quat_w_bits);
          check_field("quat_x_bits", want.quat_x_bits, out_quat_x_bits);
          check_field("quat_y_bits", want.quat_y_bits, out_quat_y_bits);
          check_field("quat_z_bits", want.quat_z_bits, out_quat_z_bits);
          check_field("yaw_rate_bits", want.yaw_rate_bits, out_yaw_rate_bits);
          check_field("pitch_rate_bits", want.pitch_rate_bits, out_pitch_rate_bits);
          check_field("projectile_speed_bits", want.projectile_speed_bits,
                      out_projectile_speed_bits);
        end
      end
      if (in_valid && !in_stall) begin
        bytes_taken++;
        if (parse_byte(in_rx_byte, in_line_error, pred)) pending_results.push_back(pred);
      end
    end
  end

  // Send one byte or line-error event and hold it until the transfer.
  task automatic push_byte(input logic [7:0] b, input logic err);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    in_line_error <= err;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic void fill_body(input logic [7:0] cmd, input int blen, input bit rand_fill,
                                    input logic [7:0] fill);
    for (int i = 0; i < blen; i++) frame_buf[i] = rand_fill ? 8'($urandom) : fill;
    frame_buf[0] = cmd;
  endfunction

  task automatic send_frame(input int blen);
    push_byte(HEADER_BYTE, 1'b0);
    push_byte(8'(blen + 2), 1'b0);
    for (int i = 0; i < blen; i++) push_byte(frame_buf[i], 1'b0);
  endtask

  // Drop valid and wait until every pending result has come out.
  task automatic wait_idle();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    // let the scoreboard book the last transfer first
    @(posedge clk);
    while (pending_results.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_results.size());
      mismatch_count++;
      pending_results.delete();
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic set_error_limit(input logic [15:0] value);
    wait_idle();
    cfg_wr_data <= value;
    cfg_wr_en <= 1'b1;
    @(posedge clk);
    err_limit = value;
    cfg_wr_en <= 1'b0;
  endtask

  task automatic test_hunt_and_bad_length();
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h55, 1'b0);
    push_byte(HEADER_BYTE, 1'b0);
    push_byte(8'd3, 1'b0);
    push_byte(HEADER_BYTE, 1'b0);
    push_byte(8'd65, 1'b0);
    push_byte(HEADER_BYTE, 1'b0);
    push_byte(8'd0, 1'b0);
    push_byte(HEADER_BYTE, 1'b0);
    push_byte(8'd255, 1'b0);
    push_byte(8'h00, 1'b1);
    push_byte(HEADER_BYTE, 1'b0);
    // the byte under a line error must be ignored
    push_byte(HEADER_BYTE, 1'b1);
  endtask

  task automatic test_frame_decode();
    fill_body(CMD_HEARTBEAT, 2, 1'b1, 8'h00);
    send_frame(2);
    fill_body(CMD_ATTITUDE, ATT_MIN_BODY, 1'b0, 8'h00);
    send_frame(ATT_MIN_BODY);
    fill_body(CMD_ATTITUDE, BODY_DEPTH, 1'b0, 8'hFF);
    send_frame(BODY_DEPTH);
    for (int m = 1; m <= 5; m++) begin
      fill_body(CMD_ATTITUDE, ATT_MIN_BODY, 1'b1, 8'h00);
      frame_buf[MODE_INDEX] = 8'(m);
      send_frame(ATT_MIN_BODY);
    end
    fill_body(CMD_ATTITUDE, ATT_MIN_BODY - 1, 1'b1, 8'h00);
    send_frame(ATT_MIN_BODY - 1);
    fill_body(8'h00, 2, 1'b1, 8'h00);
    send_frame(2);
    // abort in the middle of a body
    push_byte(HEADER_BYTE, 1'b0);
    push_byte(8'd47, 1'b0);
    push_byte(CMD_ATTITUDE, 1'b0);
    push_byte(8'h12, 1'b0);
    push_byte(CMD_ATTITUDE, 1'b1);
  endtask

  task automatic test_error_limit();
    set_error_limit(16'd0);
    push_byte(8'($urandom), 1'b1);
    fill_body(8'h7F, 3, 1'b1, 8'h00);
    send_frame(3);
    set_error_limit(16'd2);
    repeat (3) push_byte(8'($urandom), 1'b1);
    repeat (2) push_byte(8'($urandom), 1'b1);
    fill_body(CMD_HEARTBEAT, 2, 1'b1, 8'h00);
    send_frame(2);
    repeat (3) push_byte(8'($urandom), 1'b1);
    set_error_limit(16'hFFFF);
    repeat (4) push_byte(8'($urandom), 1'b1);
    // lower the limit below the running tally
    set_error_limit(16'd1);
    push_byte(8'($urandom), 1'b1);
  endtask

  task automatic send_random_frame();
    int r;
    int blen;
    int k;
    r = $urandom_range(99);
    repeat ($urandom_range(0, 2)) push_byte(8'($urandom), ($urandom_range(19) == 0));
    if (r < 50) begin
      blen = (r < 45) ? $urandom_range(ATT_MIN_BODY, ATT_MIN_BODY + 3) : BODY_DEPTH;
      fill_body(CMD_ATTITUDE, blen, 1'b1, 8'h00);
      if ($urandom_range(3) != 0) frame_buf[MODE_INDEX] = 8'($urandom_range(0, 4));
      send_frame(blen);
    end else if (r < 70) begin
      blen = $urandom_range(2, 6);
      fill_body(CMD_HEARTBEAT, blen, 1'b1, 8'h00);
      send_frame(blen);
    end else if (r < 78) begin
      blen = $urandom_range(2, ATT_MIN_BODY - 1);
      fill_body(CMD_ATTITUDE, blen, 1'b1, 8'h00);
      send_frame(blen);
    end else if (r < 85) begin
      blen = $urandom_range(2, 8);
      fill_body(8'($urandom), blen, 1'b1, 8'h00);
      if (frame_buf[0] == CMD_ATTITUDE || frame_buf[0] == CMD_HEARTBEAT) frame_buf[0] = 8'h00;
      send_frame(blen);
    end else if (r < 92) begin
      push_byte(HEADER_BYTE, 1'b0);
      push_byte($urandom_range(1) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(65, 255)), 1'b0);
    end else begin
      k = $urandom_range(0, 3);
      push_byte(HEADER_BYTE, 1'b0);
      if (k >= 1) push_byte(8'(ATT_MIN_BODY + 2), 1'b0);
      if (k >= 2) begin
        push_byte(CMD_ATTITUDE, 1'b0);
        repeat ($urandom_range(0, 10)) push_byte(8'($urandom), 1'b0);
      end
      push_byte(8'($urandom), 1'b1);
    end
  endtask

  task automatic test_random_traffic(input int idle_pct, input int hold_pct, input logic [15:0] limit);
    int start_bytes;
    int start_results;
    set_error_limit(limit);
    send_idle_pct = idle_pct;
    stall_pct = hold_pct;
    start_bytes = bytes_taken;
    start_results = results_seen;
    while (bytes_taken - start_bytes < 150 || results_seen - start_results < 3)
      send_random_frame();
  endtask

  initial begin
    for (int i = 0; i < BODY_DEPTH; i++) body_bytes[i] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_hunt_and_bad_length();
    test_frame_decode();
    test_error_limit();
    test_random_traffic(0, 0, 16'd3);
    test_random_traffic(50, 0, 16'd0);
    test_random_traffic(0, 50, 16'hFFFF);
    test_random_traffic(26, 26, 16'd7);
    wait_idle();
    if (mismatch_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
